### sv/nsq_pkg.sv
// nsq_pkg: scale codes, semitone mask table and pitch-class helper for the
// note scale quantizer. No dependencies.
`default_nettype none

package nsq_pkg;

  localparam int unsigned NoteW   = 7;
  localparam int unsigned SelW    = 3;
  localparam int unsigned PcW     = 4;
  localparam int unsigned OctSize = 12;
  localparam int unsigned MaxOff  = 6;
  localparam int unsigned OffW    = 4;
  localparam int unsigned SumW    = NoteW + 2;
  localparam logic [NoteW-1:0] NoteMax = 7'd127;

  typedef logic [NoteW-1:0]         note_t;
  typedef logic [PcW-1:0]           pc_t;
  typedef logic [OctSize-1:0]       mask_t;
  typedef logic signed [OffW-1:0]   off_t;

  typedef enum logic [SelW-1:0] {
    ScMajor     = 3'd0,
    ScMinor     = 3'd1,
    ScPentMajor = 3'd2,
    ScPentMinor = 3'd3,
    ScDorian    = 3'd4,
    ScChromatic = 3'd5
  } scale_e;

  // bit n set = semitone n of the octave is in the scale
  localparam mask_t MaskMajor     = 12'hAB5;  // 0 2 4 5 7 9 11
  localparam mask_t MaskMinor     = 12'h5AD;  // 0 2 3 5 7 8 10
  localparam mask_t MaskPentMajor = 12'h295;  // 0 2 4 7 9
  localparam mask_t MaskPentMinor = 12'h4A9;  // 0 3 5 7 10
  localparam mask_t MaskDorian    = 12'h6AD;  // 0 2 3 5 7 9 10
  localparam mask_t MaskAll       = 12'hFFF;

  function automatic mask_t scale_mask(logic [SelW-1:0] sel);
    mask_t m;
    case (scale_e'(sel))
      ScMajor:     m = MaskMajor;
      ScMinor:     m = MaskMinor;
      ScPentMajor: m = MaskPentMajor;
      ScPentMinor: m = MaskPentMinor;
      ScDorian:    m = MaskDorian;
      ScChromatic: m = MaskAll;
      default:     m = MaskAll;
    endcase
    return m;
  endfunction

  // note mod 12 by conditional subtraction of 96, 48, 24, 12
  function automatic pc_t pitch_class(note_t note);
    note_t r;
    r = note;
    if (r >= 7'd96) r = r - 7'd96;
    if (r >= 7'd48) r = r - 7'd48;
    if (r >= 7'd24) r = r - 7'd24;
    if (r >= 7'd12) r = r - 7'd12;
    return r[PcW-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/nsq_if.sv
// nsq_if: valid/ready channel interfaces for note beats and result beats.
// Depends on nsq_pkg.
`default_nettype none

interface nsq_note_if;
  logic                  valid;
  logic                  ready;
  logic [nsq_pkg::NoteW-1:0] note;
  logic [nsq_pkg::SelW-1:0]  scale_select;

  modport source (output valid, output note, output scale_select, input ready);
  modport sink   (input valid, input note, input scale_select, output ready);
endinterface

interface nsq_result_if;
  logic                  valid;
  logic                  ready;
  logic [nsq_pkg::NoteW-1:0] quantized_note;

  modport source (output valid, output quantized_note, input ready);
  modport sink   (input valid, input quantized_note, output ready);
endinterface

`default_nettype wire

### sv/nsq_pitch_search.sv
// nsq_pitch_search: nearest in-scale note search over offsets 0, -1, +1 .. -6, +6
// with saturation. Combinational. Depends on nsq_pkg.
`default_nettype none

module nsq_pitch_search (
  input  wire logic [nsq_pkg::NoteW-1:0] note_i,
  input  wire logic [nsq_pkg::SelW-1:0]  scale_select_i,
  output logic      [nsq_pkg::NoteW-1:0] quantized_note_o
);
  import nsq_pkg::*;

  mask_t mask;
  pc_t   pc;
  off_t  best;
  logic signed [SumW-1:0] sum;

  assign mask = scale_mask(scale_select_i);
  assign pc   = pitch_class(note_i);

  always_comb begin
    logic found;
    pc_t  pc_dn;
    pc_t  pc_up;
    pc_t  dd;
    found = 1'b0;
    best  = '0;
    pc_dn = '0;
    pc_up = '0;
    for (int d = 0; d <= int'(MaxOff); d++) begin
      dd    = PcW'(d);
      pc_dn = (pc >= dd) ? pc - dd : pc + PcW'(OctSize) - dd;
      pc_up = ({1'b0, pc} + {1'b0, dd} >= (PcW+1)'(OctSize)) ? pc + dd - PcW'(OctSize)
                                                                 : pc + dd;
      if (!found && mask[pc_dn]) begin
        found = 1'b1;
        best  = -off_t'(dd);
      end else if (!found && mask[pc_up]) begin
        found = 1'b1;
        best  = off_t'(dd);
      end
    end
  end

  assign sum = $signed({2'b00, note_i}) + {{(SumW-OffW){best[OffW-1]}}, best};

  always_comb begin
    if (sum[SumW-1]) begin
      quantized_note_o = '0;
    end else if (sum > $signed({2'b00, NoteMax})) begin
      quantized_note_o = NoteMax;
    end else begin
      quantized_note_o = sum[NoteW-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/note_scale_quantizer_unit.sv
// note_scale_quantizer_unit: input register, pitch search, result register.
// Depends on nsq_pkg, nsq_if and nsq_pitch_search.
//
//   channel  dir  fields
//   in_i     in   note[6:0], scale_select[2:0]
//   out_o    out  quantized_note[6:0]
//
// One beat per cycle sustained while out_o.ready holds; a result enters res_q once the output stage can advance.
// The search sits between the input register and the result register.
// Reset clears both valid flags; no state is kept between beats.
// A stalled result holds in its register while the input stage may still fill.
`default_nettype none

module note_scale_quantizer_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  nsq_note_if.sink      in_i,
  nsq_result_if.source  out_o
);
  import nsq_pkg::*;

  logic                  in_vld_q;
  note_t                 note_q;
  logic [SelW-1:0]       sel_q;
  logic                  out_vld_q;
  note_t                 res_q;
  note_t                 res_d;
  logic                  out_adv;
  logic                  in_adv;

  assign out_adv  = !out_vld_q || out_o.ready;
  assign in_adv   = in_vld_q && out_adv;
  assign in_i.ready = !in_vld_q || out_adv;

  nsq_pitch_search u_search (
    .note_i           (note_q),
    .scale_select_i   (sel_q),
    .quantized_note_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      note_q <= in_i.note;
      sel_q  <= in_i.scale_select;
    end
    if (in_adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.quantized_note = res_q;

endmodule

`default_nettype wire

### tb/note_scale_quantizer_unit_test.sv
// note_scale_quantizer_unit_test: self-checking bench for note_scale_quantizer_unit.
// Directed table plus random note beats, scored against typed expectations or a local scale-snap predictor.
// Depends on nsq_pkg, nsq_if and the unit RTL.
`timescale 1ns / 1ps

module note_scale_quantizer_unit_test;
  import nsq_pkg::*;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned RandBeats  = 550;
  localparam int unsigned GapPct     = 8;
  localparam int unsigned Drain      = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportMax  = 10;

  localparam logic [SelW-1:0] SelSpare6 = 3'd6;
  localparam logic [SelW-1:0] SelSpare7 = 3'd7;
  localparam logic Typed = 1'b1;
  localparam logic Pred  = 1'b0;

  typedef struct packed {
    note_t           note;
    logic [SelW-1:0] sel;
    logic            typed;
    note_t           want;
  } probe_t;

  localparam int unsigned NumProbes = 24;

  probe_t probes [NumProbes] = '{
    {7'd0,   3'(ScMajor),     Typed, 7'd0},
    {7'd127, 3'(ScMajor),     Typed, 7'd127},
    {7'd1,   3'(ScMajor),     Typed, 7'd0},    // tie between 0 and 2 goes down
    {7'd0,   3'(ScChromatic), Typed, 7'd0},
    {7'd127, 3'(ScChromatic), Typed, 7'd127},
    {7'd61,  3'(ScChromatic), Typed, 7'd61},
    {7'd85,  SelSpare6,       Typed, 7'd85},   // unused selectors pass through
    {7'd42,  SelSpare7,       Typed, 7'd42},
    {7'd127, SelSpare7,       Typed, 7'd127},
    {7'd126, 3'(ScPentMinor), Typed, 7'd125},
    {7'd119, 3'(ScPentMajor), Typed, 7'd120},  // wraps up into next octave
    {7'd0,   3'(ScPentMinor), Typed, 7'd0},
    {7'd0,   3'(ScDorian),    Typed, 7'd0},
    {7'd127, 3'(ScMinor),     Typed, 7'd127},
    {7'd127, 3'(ScDorian),    Typed, 7'd127},
    {7'd127, 3'(ScPentMinor), Typed, 7'd127},
    {7'd127, 3'(ScPentMajor), Typed, 7'd127},
    {7'd66,  3'(ScMajor),     Pred,  7'd0},
    {7'd70,  3'(ScMinor),     Pred,  7'd0},
    {7'd13,  3'(ScPentMajor), Pred,  7'd0},
    {7'd50,  3'(ScPentMinor), Pred,  7'd0},
    {7'd64,  3'(ScDorian),    Pred,  7'd0},
    {7'd101, 3'(ScMinor),     Pred,  7'd0},
    {7'd125, 3'(ScPentMajor), Pred,  7'd0}
  };

  logic clk;
  logic rst_n;

  nsq_note_if   note_bus ();
  nsq_result_if result_bus ();

  note_scale_quantizer_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (note_bus),
    .out_o  (result_bus)
  );

  note_t       snapped_q [$];
  bit          gaps_on;
  int unsigned mismatches;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned cycles;
  int unsigned sel_hits [8];

  // nearest in-scale note, downward on ties, clamped to the MIDI range
  function automatic note_t snap_to_scale(note_t n, logic [SelW-1:0] sel);
    mask_t m;
    int    pc;
    int    off;
    int    sum;
    bit    found;
    case (sel)
      ScMajor:     m = 12'b1010_1011_0101;  // 0 2 4 5 7 9 11
      ScMinor:     m = 12'b0101_1010_1101;  // 0 2 3 5 7 8 10
      ScPentMajor: m = 12'b0010_1001_0101;  // 0 2 4 7 9
      ScPentMinor: m = 12'b0100_1010_1001;  // 0 3 5 7 10
      ScDorian:    m = 12'b0110_1010_1101;  // 0 2 3 5 7 9 10
      default:     return n;
    endcase
    pc    = int'(n) % 12;
    off   = 0;
    found = 1'b0;
    for (int d = 0; d <= 6 && !found; d++) begin
      if (m[(pc - d + 12) % 12]) begin
        off   = -d;
        found = 1'b1;
      end else if (m[(pc + d) % 12]) begin
        off   = d;
        found = 1'b1;
      end
    end
    sum = int'(n) + off;
    if (sum < 0) sum = 0;
    if (sum > int'(NoteMax)) sum = int'(NoteMax);
    return note_t'(sum);
  endfunction

  task automatic send_beat(input note_t n, input logic [SelW-1:0] s, input note_t want);
    while (gaps_on && $urandom_range(0, 99) < GapPct) begin
      note_bus.valid <= 1'b0;
      @(posedge clk);
    end
    note_bus.valid        <= 1'b1;
    note_bus.note         <= n;
    note_bus.scale_select <= s;
    @(posedge clk);
    while (!note_bus.ready) @(posedge clk);
    snapped_q.push_back(want);
    beats_in++;
    sel_hits[s]++;
  endtask

  task automatic drain_results();
    note_bus.valid <= 1'b0;
    @(posedge clk);
    while (snapped_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, snapped_q.size());
      $display("note_scale_quantizer_unit_test: errors");
      $finish;
    end
  end

  initial begin
    result_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      result_bus.ready <= !(gaps_on && $urandom_range(0, 99) < GapPct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      beats_out++;
      if (snapped_q.size() == 0) begin
        if (mismatches < ReportMax)
          $display("unexpected result beat: quantized_note=%0d", result_bus.quantized_note);
        mismatches++;
      end else begin
        note_t want;
        want = snapped_q.pop_front();
        if (result_bus.quantized_note !== want) begin
          if (mismatches < ReportMax)
            $display("quantized_note mismatch on result %0d: expected %0d, got %0d",
                     beats_out, want, result_bus.quantized_note);
          mismatches++;
        end
      end
    end
  end

  initial begin
    note_t           n;
    logic [SelW-1:0] s;
    int unsigned     r;

    rst_n                 = 1'b0;
    gaps_on               = 1'b1;
    note_bus.valid        = 1'b0;
    note_bus.note         = '0;
    note_bus.scale_select = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      send_beat(probes[i].note, probes[i].sel,
                probes[i].typed ? probes[i].want
                                : snap_to_scale(probes[i].note, probes[i].sel));
    end
    drain_results();

    for (int unsigned k = 0; k < RandBeats; k++) begin
      gaps_on = !(k >= 250 && k < 350);
      if (k == 400) drain_results();
      r = $urandom_range(0, 99);
      if (r < 80)      s = SelW'($urandom_range(0, 4));
      else if (r < 90) s = ScChromatic;
      else             s = SelW'($urandom_range(6, 7));
      r = $urandom_range(0, 99);
      if (r < 8)       n = NoteW'($urandom_range(0, 5));
      else if (r < 16) n = NoteW'($urandom_range(122, 127));
      else             n = NoteW'($urandom_range(0, 127));
      send_beat(n, s, snap_to_scale(n, s));
    end

    drain_results();
    repeat (Drain) @(posedge clk);
    mismatches += snapped_q.size();

    $display("%0d note beats sent, %0d results checked in %0d cycles",
             beats_in, beats_out, cycles);
    $display("beats per selector 0..7: %0d %0d %0d %0d %0d %0d %0d %0d, mismatches %0d",
             sel_hits[0], sel_hits[1], sel_hits[2], sel_hits[3],
             sel_hits[4], sel_hits[5], sel_hits[6], sel_hits[7], mismatches);
    if (mismatches == 0) begin
      $display("note_scale_quantizer_unit_test: clean");
    end else begin
      $display("note_scale_quantizer_unit_test: errors");
    end
    $finish;
  end

endmodule
